// ===== rtl/lkv_pkg.sv =====
// Package for the LRU key/value cache: field widths, defaults and controller types.
`timescale 1ns / 1ps
package lkv_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 31;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SETTLE,
		ST_DECIDE,
		ST_UPDATE,
		ST_FLUSH
	} lkv_state_t;

	typedef enum logic {
		UPD_TOUCH,
		UPD_INSERT
	} lkv_mode_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative key/value cache with least-recently-used replacement.
`timescale 1ns / 1ps
// Channel   Direction  Item
// s_*       in         one get or put: key and value in tdata, kind in tuser
// m_*       out        one get answer: value in tdata, found flag in tuser
// cfg_*     in         write of the capacity register
//
// An item first scans all ENTRIES words of the entry RAM, one read a cycle;
// a get miss or an ignored put ends there.
// A hit or an insert then rewrites the ages in a second read-modify-write pass over the RAM.
// Reset clears the valid bits and the occupancy; the RAM contents need no clearing.
// A get answer waits in the output register; a second answer holds the block until it is taken.
module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,   // lookup_key [31:0], store_value [62:32], zero [63]
	input  logic             s_tuser,   // kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // read_value [30:0], zero [31]
	output logic             m_tuser,   // found
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AW = IW;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int XW = (CW > CAP_W) ? CW : CAP_W;
	localparam int WW = KEY_W + VAL_W + AW;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	lkv_state_t state_q, state_d;
	lkv_mode_t mode_q;

	logic [CAP_W-1:0] cap_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0] occ_q;

	logic kind_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	logic [IW-1:0] cnt_q;
	logic rv_s1;
	logic [IW-1:0] ri_s1;

	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [AW-1:0] hit_age_q;
	logic [VAL_W-1:0] hit_val_q;
	logic old_have_q;
	logic [IW-1:0] old_idx_q;
	logic [AW-1:0] old_age_q;
	logic free_have_q;
	logic [IW-1:0] free_idx_q;

	logic [IW-1:0] tgt_q;
	logic [AW-1:0] tgt_age_q;
	logic [VAL_W-1:0] nv_q;

	logic m_tvalid_q;
	logic found_q;
	logic [VAL_W-1:0] rdval_q;

	logic [WW-1:0] ram_rdata;
	logic [WW-1:0] ram_wdata;
	logic ram_we;
	logic ram_re;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic [AW-1:0] rd_age;
	logic [AW-1:0] age_new;

	logic in_acc;
	logic out_free;
	logic [XW-1:0] cap_x;
	logic cap_zero;
	logic evict;
	logic slot_ok;
	logic [IW-1:0] slot_idx;
	logic dec_fire;
	logic scan_phase;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tuser = found_q;
	assign m_tdata = {1'b0, rdval_q};

	assign rd_key = ram_rdata[KEY_W-1:0];
	assign rd_val = ram_rdata[KEY_W +: VAL_W];
	assign rd_age = ram_rdata[KEY_W + VAL_W +: AW];

	assign out_free = !m_tvalid_q || m_tready;
	assign cap_x = (XW'(cap_q) > XW'(ENTRIES)) ? XW'(ENTRIES) : XW'(cap_q);
	assign cap_zero = (cap_x == '0);
	assign evict = (XW'(occ_q) >= cap_x) && old_have_q;
	assign slot_ok = evict || free_have_q;
	assign slot_idx = (evict && (!free_have_q || old_idx_q < free_idx_q)) ? old_idx_q
		: free_idx_q;
	assign dec_fire = (state_q == ST_DECIDE) && (kind_q || out_free);
	assign scan_phase = (state_q == ST_SCAN) || (state_q == ST_SETTLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!kind_q) begin
					if (out_free) begin
						state_d = hit_q ? ST_UPDATE : ST_IDLE;
					end
				end else if (cap_zero) begin
					state_d = ST_IDLE;
				end else if (hit_q || slot_ok) begin
					state_d = ST_UPDATE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_UPDATE: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ram_re = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
	assign ram_we = rv_s1 && ((state_q == ST_UPDATE) || (state_q == ST_FLUSH));

	always_comb begin
		age_new = rd_age;
		if (valid_q[ri_s1] && ((mode_q == UPD_INSERT) || (rd_age < tgt_age_q))) begin
			age_new = rd_age + AW'(1);
		end
		if (ri_s1 == tgt_q) begin
			ram_wdata = {AW'(0), nv_q, key_q};
		end else begin
			ram_wdata = {age_new, rd_val, rd_key};
		end
	end

	lkv_ram #(
		.WIDTH(WW),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ri_s1),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			valid_q <= '0;
			occ_q <= '0;
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			hit_q <= 1'b0;
			old_have_q <= 1'b0;
			free_have_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			mode_q <= UPD_TOUCH;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end

			rv_s1 <= ram_re;
			if (ram_re) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IW'(1);
			end

			if (in_acc) begin
				hit_q <= 1'b0;
				old_have_q <= 1'b0;
				free_have_q <= 1'b0;
			end else if (rv_s1 && scan_phase) begin
				if (valid_q[ri_s1]) begin
					if (rd_key == key_q) begin
						hit_q <= 1'b1;
					end
					if (!old_have_q || rd_age > old_age_q) begin
						old_have_q <= 1'b1;
					end
				end else if (!free_have_q) begin
					free_have_q <= 1'b1;
				end
			end

			if (dec_fire && !kind_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (dec_fire) begin
				if (!kind_q) begin
					mode_q <= UPD_TOUCH;
				end else if (!cap_zero) begin
					if (hit_q) begin
						mode_q <= UPD_TOUCH;
					end else if (slot_ok) begin
						mode_q <= UPD_INSERT;
						if (evict) begin
							valid_q <= (valid_q & ~(ENTRIES'(1) << old_idx_q))
								| (ENTRIES'(1) << slot_idx);
						end else begin
							valid_q <= valid_q | (ENTRIES'(1) << slot_idx);
							occ_q <= occ_q + CW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= cnt_q;
		if (in_acc) begin
			kind_q <= s_tuser;
			key_q <= s_tdata[KEY_W-1:0];
			val_q <= s_tdata[KEY_W +: VAL_W];
		end else if (rv_s1 && scan_phase) begin
			if (valid_q[ri_s1]) begin
				if (rd_key == key_q) begin
					hit_idx_q <= ri_s1;
					hit_age_q <= rd_age;
					hit_val_q <= rd_val;
				end
				if (!old_have_q || rd_age > old_age_q) begin
					old_idx_q <= ri_s1;
					old_age_q <= rd_age;
				end
			end else if (!free_have_q) begin
				free_idx_q <= ri_s1;
			end
		end

		if (dec_fire) begin
			if (!kind_q) begin
				found_q <= hit_q;
				rdval_q <= hit_q ? hit_val_q : '0;
				tgt_q <= hit_idx_q;
				tgt_age_q <= hit_age_q;
				nv_q <= hit_val_q;
			end else if (hit_q) begin
				tgt_q <= hit_idx_q;
				tgt_age_q <= hit_age_q;
				nv_q <= val_q;
			end else begin
				tgt_q <= slot_idx;
				tgt_age_q <= '0;
				nv_q <= val_q;
			end
		end
	end

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupancy count differs from the number of valid entries");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= ENTRIES)
		else $error("occupancy exceeds the number of entries");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN))
		else $error("accepted item did not start a scan");

	a_answer_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DECIDE && !kind_q))
		else $error("answer raised outside the decision of a get");

	a_write_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(state_q == ST_UPDATE))
		else $error("entry RAM written outside the update pass");

endmodule

// ===== rtl/lkv_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module lkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
